FILE: sv/lss_pkg.sv
package lss_pkg;

  localparam int COEF_BITS_DEF = 16;
  localparam int SOL_BITS      = 32;
  localparam int OUT_FRAC      = 16;
  localparam int FIFO_DEPTH    = 4;

  localparam logic [1:0] ST_UNIQUE = 2'd0;
  localparam logic [1:0] ST_INF    = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;

  // 2x2 minors of rows 2 and 3, column pairs (i,j) with i<j
  localparam int PI [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PJ [6] = '{1, 2, 3, 2, 3, 3};

  // row 1 expansion of D, D1, D2, D3: column, minor, subtract
  localparam int DCOL [4][3] = '{'{0, 1, 2}, '{3, 1, 2}, '{0, 3, 2}, '{0, 1, 3}};
  localparam int DPAIR [4][3] = '{'{3, 1, 0}, '{3, 5, 4}, '{5, 1, 2}, '{4, 2, 0}};
  localparam logic DNEG [4][3] = '{'{1'b0, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b1},
                                   '{1'b1, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b0}};

  typedef struct packed {
    logic       sing;
    logic [1:0] status;
  } ctl_t;

endpackage

FILE: sv/lss_front.sv
module lss_front #(
  parameter int COEF_BITS = lss_pkg::COEF_BITS_DEF,
  parameter int MW        = 3 * COEF_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COEF_BITS-1:0] m [3][4],
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [MW-1:0]               den,
  output logic [MW-1:0]               num [3],
  output logic [2:0]                  neg,
  output lss_pkg::ctl_t               ctl
);

  localparam int P2 = 2 * COEF_BITS;
  localparam int M2 = 2 * COEF_BITS + 1;
  localparam int T3 = 3 * COEF_BITS + 1;
  localparam int DW = 3 * COEF_BITS + 3;

  logic [3:0] v_r;
  logic en;

  logic signed [COEF_BITS-1:0] r0a_r [4];
  logic signed [COEF_BITS-1:0] r0b_r [4];
  logic signed [P2-1:0] pa_r [6];
  logic signed [P2-1:0] pb_r [6];
  logic signed [M2-1:0] mn_r [6];
  logic signed [T3-1:0] tp_r [4][3];
  logic signed [DW-1:0] det_r [4];
  logic signed [DW-1:0] det_nxt [4];
  logic signed [DW-1:0] mag [4];

  assign en       = !v_r[3] || out_ready;
  assign in_ready = en;
  assign out_valid = v_r[3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      det_nxt[k] = '0;
      for (int t = 0; t < 3; t++) begin
        if (lss_pkg::DNEG[k][t]) det_nxt[k] = det_nxt[k] - DW'(tp_r[k][t]);
        else det_nxt[k] = det_nxt[k] + DW'(tp_r[k][t]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        r0a_r[c] <= m[0][c];
        r0b_r[c] <= r0a_r[c];
      end
      for (int p = 0; p < 6; p++) begin
        pa_r[p] <= P2'(m[1][lss_pkg::PI[p]]) * P2'(m[2][lss_pkg::PJ[p]]);
        pb_r[p] <= P2'(m[1][lss_pkg::PJ[p]]) * P2'(m[2][lss_pkg::PI[p]]);
        mn_r[p] <= M2'(pa_r[p]) - M2'(pb_r[p]);
      end
      for (int k = 0; k < 4; k++) begin
        for (int t = 0; t < 3; t++) begin
          tp_r[k][t] <= T3'(r0b_r[lss_pkg::DCOL[k][t]]) * T3'(mn_r[lss_pkg::DPAIR[k][t]]);
        end
        det_r[k] <= det_nxt[k];
      end
    end
  end

  // magnitudes and quotient signs for the divider
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = det_r[k][DW-1] ? -det_r[k] : det_r[k];
    end
    den = mag[0][MW-1:0];
    for (int k = 0; k < 3; k++) begin
      num[k] = mag[k+1][MW-1:0];
      neg[k] = det_r[k+1][DW-1] ^ det_r[0][DW-1];
    end
    ctl.sing = (det_r[0] == '0);
    if (!ctl.sing) ctl.status = lss_pkg::ST_UNIQUE;
    else if (det_r[1] == '0 && det_r[2] == '0 && det_r[3] == '0) ctl.status = lss_pkg::ST_INF;
    else ctl.status = lss_pkg::ST_NONE;
  end

endmodule

FILE: sv/lss_fifo.sv
module lss_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = lss_pkg::FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic push, pop;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem[wp_r] <= wr_data;
  end

endmodule

FILE: sv/lss_back.sv
module lss_back #(
  parameter int MW = 3 * lss_pkg::COEF_BITS_DEF + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [MW-1:0]                den,
  input  logic [MW-1:0]                num [3],
  input  logic [2:0]                   neg,
  input  lss_pkg::ctl_t                ctl,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lss_pkg::SOL_BITS-1:0] sol [3],
  output logic [1:0]                   status,
  output logic                         saturated
);

  localparam int QW = lss_pkg::SOL_BITS;
  localparam int OF = lss_pkg::OUT_FRAC;
  localparam int NS = QW;

  logic en;
  logic [NS:0]      v_r;
  logic [MW-1:0]    den_r [NS+1];
  lss_pkg::ctl_t    ctl_r [NS+1];
  logic [2:0]       neg_r [NS+1];
  logic [2:0]       ovf_r [NS+1];
  logic [MW-1:0]    rem_r [NS+1][3];
  logic [QW-1:0]    nl_r  [NS+1][3];
  logic [QW-1:0]    q_r   [NS+1][3];

  logic [MW:0]      tr   [NS][3];
  logic [MW:0]      diff [NS][3];
  logic             ge   [NS][3];

  logic [QW-1:0]    lim [3];
  logic [QW-1:0]    mag [3];
  logic [2:0]       sat;

  logic             out_valid_r;
  logic [QW-1:0]    sol_r [3];
  logic [1:0]       status_r;
  logic             sat_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign sol       = sol_r;
  assign status    = status_r;
  assign saturated = sat_r;

  // one quotient bit per stage
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < 3; l++) begin
        tr[s][l]   = {rem_r[s][l], nl_r[s][l][QW-1]};
        diff[s][l] = tr[s][l] - {1'b0, den_r[s]};
        ge[s][l]   = (tr[s][l] >= {1'b0, den_r[s]});
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lim[l] = neg_r[NS][l] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      sat[l] = ovf_r[NS][l] || (q_r[NS][l] > lim[l]);
      mag[l] = sat[l] ? lim[l] : q_r[NS][l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NS-1:0], in_valid};
      out_valid_r <= v_r[NS];
    end
    if (en) begin
      den_r[0] <= den;
      ctl_r[0] <= ctl;
      neg_r[0] <= neg;
      for (int l = 0; l < 3; l++) begin
        // quotient would need more than QW bits
        ovf_r[0][l] <= ((MW+OF)'(num[l]) >= {den, {OF{1'b0}}});
        rem_r[0][l] <= MW'(num[l][MW-1:OF]);
        nl_r[0][l]  <= {num[l][OF-1:0], {(QW-OF){1'b0}}};
        q_r[0][l]   <= '0;
      end
      for (int s = 0; s < NS; s++) begin
        den_r[s+1] <= den_r[s];
        ctl_r[s+1] <= ctl_r[s];
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
        for (int l = 0; l < 3; l++) begin
          rem_r[s+1][l] <= ge[s][l] ? diff[s][l][MW-1:0] : tr[s][l][MW-1:0];
          nl_r[s+1][l]  <= {nl_r[s][l][QW-2:0], 1'b0};
          q_r[s+1][l]   <= {q_r[s][l][QW-2:0], ge[s][l]};
        end
      end
      status_r <= ctl_r[NS].status;
      sat_r    <= !ctl_r[NS].sing && (|sat);
      for (int l = 0; l < 3; l++) begin
        if (ctl_r[NS].sing) sol_r[l] <= '0;
        else sol_r[l] <= neg_r[NS][l] ? -mag[l] : mag[l];
      end
    end
  end

endmodule

FILE: sv/linear_system_3x3_solver.sv
// 3x3 linear system solver by Cramer's rule. Each item is nine signed
// coefficients and three right-hand sides; the result is x, y, z in signed
// Q16.16 (truncated toward zero, saturated with out_saturated set), or zeros
// with out_status telling infinite solutions from no solution when the main
// determinant is zero. One system is taken per clock cycle when the output
// is not stalled. A system passes the determinant pipeline, the four-entry
// queue, then 33 register stages of the divider, the first holding the
// operands and each later one adding one quotient bit for all three
// unknowns, and the output register. Coefficient width follows COEF_BITS.
module linear_system_3x3_solver #(
  parameter int COEF_BITS = lss_pkg::COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COEF_BITS-1:0] in_a11,
  input  logic signed [COEF_BITS-1:0] in_a12,
  input  logic signed [COEF_BITS-1:0] in_a13,
  input  logic signed [COEF_BITS-1:0] in_b1,
  input  logic signed [COEF_BITS-1:0] in_a21,
  input  logic signed [COEF_BITS-1:0] in_a22,
  input  logic signed [COEF_BITS-1:0] in_a23,
  input  logic signed [COEF_BITS-1:0] in_b2,
  input  logic signed [COEF_BITS-1:0] in_a31,
  input  logic signed [COEF_BITS-1:0] in_a32,
  input  logic signed [COEF_BITS-1:0] in_a33,
  input  logic signed [COEF_BITS-1:0] in_b3,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_sol_x,
  output logic signed [31:0]          out_sol_y,
  output logic signed [31:0]          out_sol_z,
  output logic [1:0]                  out_status,
  output logic                        out_saturated
);

  localparam int MW = 3 * COEF_BITS + 1;
  localparam int FW = 4 * MW + 3 + $bits(lss_pkg::ctl_t);

  logic signed [COEF_BITS-1:0] m [3][4];
  logic f_valid, f_ready, b_valid, b_ready;
  logic [MW-1:0] f_den, b_den;
  logic [MW-1:0] f_num [3];
  logic [MW-1:0] b_num [3];
  logic [2:0] f_neg, b_neg;
  lss_pkg::ctl_t f_ctl, b_ctl;
  logic [FW-1:0] f_word, b_word;
  logic [lss_pkg::SOL_BITS-1:0] sol [3];

  assign m[0] = '{in_a11, in_a12, in_a13, in_b1};
  assign m[1] = '{in_a21, in_a22, in_a23, in_b2};
  assign m[2] = '{in_a31, in_a32, in_a33, in_b3};

  lss_front #(.COEF_BITS(COEF_BITS), .MW(MW)) u_front (
    .clk, .rst_n,
    .in_valid, .in_ready, .m,
    .out_valid(f_valid), .out_ready(f_ready),
    .den(f_den), .num(f_num), .neg(f_neg), .ctl(f_ctl)
  );

  assign f_word = {f_den, f_num[0], f_num[1], f_num[2], f_neg, f_ctl};
  assign {b_den, b_num[0], b_num[1], b_num[2], b_neg, b_ctl} = b_word;

  lss_fifo #(.W(FW), .DEPTH(lss_pkg::FIFO_DEPTH)) u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_word),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_word)
  );

  lss_back #(.MW(MW)) u_back (
    .clk, .rst_n,
    .in_valid(b_valid), .in_ready(b_ready),
    .den(b_den), .num(b_num), .neg(b_neg), .ctl(b_ctl),
    .out_valid, .out_ready,
    .sol, .status(out_status), .saturated(out_saturated)
  );

  assign out_sol_x = sol[0];
  assign out_sol_y = sol[1];
  assign out_sol_z = sol[2];

endmodule

FILE: sv/lss_checker.sv
module lss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sol_x,
  input logic [31:0] out_sol_y,
  input logic [31:0] out_sol_z,
  input logic [1:0]  out_status,
  input logic        out_saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sol_x) && $stable(out_status))
    else $error("result changed while stalled");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lss_pkg::ST_UNIQUE |->
      out_sol_x == '0 && out_sol_y == '0 && out_sol_z == '0 && !out_saturated)
    else $error("singular system with nonzero solution");

  a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_sol_x == 32'h7fffffff || out_sol_x == 32'h80000000 ||
      out_sol_y == 32'h7fffffff || out_sol_y == 32'h80000000 ||
      out_sol_z == 32'h7fffffff || out_sol_z == 32'h80000000)
    else $error("saturated flag without clipped value");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind linear_system_3x3_solver lss_checker u_lss_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_sol_x, .out_sol_y, .out_sol_z,
  .out_status, .out_saturated
);

FILE: tb/sv/linear_system_3x3_solver_test.sv
module linear_system_3x3_solver_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [11:0][15:0] system_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  status;
    logic        sat;
  } solution_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  system_t cur_sys = '0;
  logic signed [31:0] out_sol_x, out_sol_y, out_sol_z;
  logic [1:0] out_status;
  logic out_saturated;

  system_t pending_systems[$];
  solution_t expected_solutions[$];
  int n_sent = 0, n_checked = 0, n_errors = 0;
  int n_unique = 0, n_inf = 0, n_none = 0, n_sat = 0;
  int send_gap = 0, recv_gap = 0;
  bit stim_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  linear_system_3x3_solver DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a11(cur_sys[0]), .in_a12(cur_sys[1]), .in_a13(cur_sys[2]), .in_b1(cur_sys[3]),
    .in_a21(cur_sys[4]), .in_a22(cur_sys[5]), .in_a23(cur_sys[6]), .in_b2(cur_sys[7]),
    .in_a31(cur_sys[8]), .in_a32(cur_sys[9]), .in_a33(cur_sys[10]), .in_b3(cur_sys[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sol_x(out_sol_x), .out_sol_y(out_sol_y), .out_sol_z(out_sol_z),
    .out_status(out_status), .out_saturated(out_saturated)
  );

  function automatic logic signed [127:0] cofactor_det(system_t s, int c0, int c1, int c2);
    logic signed [127:0] m[3][4];
    logic signed [127:0] p, q, r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++)
        m[i][j] = 128'(signed'(s[i*4+j]));
    p = m[1][c1] * m[2][c2] - m[1][c2] * m[2][c1];
    q = m[1][c0] * m[2][c2] - m[2][c0] * m[1][c2];
    r = m[1][c0] * m[2][c1] - m[2][c0] * m[1][c1];
    return m[0][c0] * p - m[0][c1] * q + m[0][c2] * r;
  endfunction

  // quotient in q16.16, truncated toward zero and clipped to 32 bits
  function automatic logic [31:0] q16_ratio(logic signed [127:0] num,
                                            logic signed [127:0] den, ref logic sat);
    logic signed [127:0] q;
    q = (num <<< 16) / den;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  function automatic solution_t cramer_solve(system_t s);
    solution_t r;
    logic signed [127:0] d, d1, d2, d3;
    logic sat;
    sat = 1'b0;
    r = '0;
    d  = cofactor_det(s, 0, 1, 2);
    d1 = cofactor_det(s, 3, 1, 2);
    d2 = cofactor_det(s, 0, 3, 2);
    d3 = cofactor_det(s, 0, 1, 3);
    if (d != 0) begin
      r.x = q16_ratio(d1, d, sat);
      r.y = q16_ratio(d2, d, sat);
      r.z = q16_ratio(d3, d, sat);
      r.status = lss_pkg::ST_UNIQUE;
    end else begin
      r.status = (d1 == 0 && d2 == 0 && d3 == 0) ? lss_pkg::ST_INF : lss_pkg::ST_NONE;
    end
    r.sat = sat;
    return r;
  endfunction

  function automatic logic [15:0] small_val();
    return 16'($signed($urandom_range(0, 16)) - 8) <<< $urandom_range(0, 8);
  endfunction

  function automatic system_t random_system();
    system_t s;
    int kind;
    int k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++)
      s[i] = (kind < 4) ? 16'($urandom) : small_val();
    if (kind >= 7) begin
      // dependent rows give a singular matrix, consistent or not
      k = $signed($urandom_range(0, 4)) - 2;
      for (int j = 0; j < 4; j++)
        s[8+j] = 16'(k * $signed(s[j]));
      if (kind == 9)
        s[11] = s[11] + 16'($urandom_range(1, 50));
    end else if (kind == 6) begin
      // tiny determinant with big right-hand sides to push saturation
      for (int i = 0; i < 12; i++)
        s[i] = (i % 4 == 3) ? 16'($urandom) : 16'($signed($urandom_range(0, 4)) - 2);
    end
    return s;
  endfunction

  initial begin
    system_t s;
    s = '0;
    pending_systems.push_back(s);
    s[0] = 16'h0100; s[5] = 16'h0100; s[10] = 16'h0100;
    s[3] = 16'h0200; s[7] = 16'hFF00; s[11] = 16'h0080;
    pending_systems.push_back(s);
    s = {12{16'h7FFF}};
    pending_systems.push_back(s);
    s = {12{16'h8000}};
    pending_systems.push_back(s);
    s = '0; s[0] = 16'h0001; s[5] = 16'h0001; s[10] = 16'h0001;
    s[3] = 16'h7FFF; s[7] = 16'h8000; s[11] = 16'h7FFF;
    pending_systems.push_back(s);
    s[0] = 16'hFFFF; s[3] = 16'h7FFF; s[7] = 16'h8001;
    pending_systems.push_back(s);
    s = '0; s[0] = 16'h8000; s[5] = 16'h7FFF; s[10] = 16'h8000;
    s[3] = 16'h8000; s[7] = 16'h7FFF; s[11] = 16'h0001;
    pending_systems.push_back(s);
    s = '0; s[0] = 16'h0100; s[1] = 16'h0100; s[4] = 16'h0100; s[5] = 16'h0100;
    s[10] = 16'h0100; s[3] = 16'h0100; s[7] = 16'h0200;
    pending_systems.push_back(s);
    s[7] = 16'h0100;
    pending_systems.push_back(s);
    s = '0; s[3] = 16'h0001;
    pending_systems.push_back(s);
    s = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
         16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB, 16'h5555, 16'hAAAA};
    pending_systems.push_back(s);
    for (int i = 0; i < 1100; i++)
      pending_systems.push_back(random_system());
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver, with prediction on each accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_solutions.push_back(cramer_solve(cur_sys));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_systems.size() > 0) begin
          cur_sys <= pending_systems.pop_front();
          in_valid <= 1'b1;
          send_gap = ($urandom_range(0, 9) < 6) ? 0 :
                     ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
                     $urandom_range(10, 40);
        end else begin
          in_valid <= 1'b0;
          stim_done = 1'b1;
        end
      end
    end
  end

  // monitor and back-pressure
  always @(posedge clk) begin
    solution_t exp_sol, got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_sol_x, out_sol_y, out_sol_z, out_status, out_saturated};
        if (expected_solutions.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result word: %p", got);
        end else begin
          exp_sol = expected_solutions.pop_front();
          n_checked++;
          case (exp_sol.status)
            lss_pkg::ST_UNIQUE: n_unique++;
            lss_pkg::ST_INF:    n_inf++;
            default:            n_none++;
          endcase
          if (exp_sol.sat)
            n_sat++;
          if (got !== exp_sol) begin
            n_errors++;
            if (n_errors <= 10)
              $display({"mismatch on result %0d: expected x=%h y=%h z=%h st=%0d sat=%b,",
                        " got x=%h y=%h z=%h st=%0d sat=%b"},
                       n_checked, exp_sol.x, exp_sol.y, exp_sol.z, exp_sol.status,
                       exp_sol.sat, got.x, got.y, got.z, got.status, got.sat);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = ($urandom_range(0, 9) < 6) ? 0 :
                   ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
                   $urandom_range(10, 40);
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_solutions.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d systems sent, %0d results checked", n_sent, n_checked);
    $display("unique %0d (saturated %0d), infinite %0d, no solution %0d",
             n_unique, n_sat, n_inf, n_none);
    if (n_errors == 0 && expected_solutions.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
